[rtl/bm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_pkg
// shared types, register map and defaults of the 3x3 morphology filter
// ----------------------------------------------------------------------------
package bm_pkg;

  // default values of the top level parameters and the queue depth
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;
  localparam int FIFO_DEPTH_DEF = 2;

  // stream field widths
  localparam int PIX_PORT_W = 8;

  // configuration port
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;
  localparam int CFG_W   = 11;
  localparam int MODE_W  = 2;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

  // reset values of the registers
  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [MODE_W-1:0] RST_FILTER_MODE  = MODE_OPEN;

  // window operation of one stage
  typedef enum logic [1:0] {
    OP_AND,
    OP_OR,
    OP_PASS
  } op_t;

  typedef struct packed {
    logic [CFG_W-1:0]  frame_width;
    logic [CFG_W-1:0]  frame_height;
    logic [MODE_W-1:0] filter_mode;
  } cfg_t;

  // control word of one item, front to back
  typedef struct packed {
    op_t  op1;
    op_t  op2;
    logic border1;
    logic s2_en;
    logic border2;
    logic out_en;
    logic last;
  } ctl_t;

endpackage

[rtl/bm_stream_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_in_if / bm_out_if
// valid/ready channels for pixel words in and filtered words out
// ----------------------------------------------------------------------------
interface bm_in_if;
  import bm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] pixel_in;
  logic                  drain;

  modport source (output valid, output pixel_in, output drain, input ready);
  modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface bm_out_if;
  import bm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] pixel_out;
  logic                  frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

[rtl/bm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module bm_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/bm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_front
// accepts words, tracks frame positions and classifies each word
// ----------------------------------------------------------------------------
module bm_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bm_pkg::cfg_t                 cfg,
  bm_in_if.sink                        pixels,
  output logic                         push_valid,
  input  logic                         push_ready,
  output bm_pkg::ctl_t                 push_ctl,
  output logic [PIXEL_BITS-1:0]        push_pix,
  output logic [$clog2(MAX_WIDTH)-1:0] push_col1,
  output logic [$clog2(MAX_WIDTH)-1:0] push_col2
);
  import bm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = CFG_W + 1;

  logic              started;
  logic [WW-1:0]     act_w;
  logic [CFG_W-1:0]  act_h;
  logic [MODE_W-1:0] act_mode;
  logic [RW-1:0]     row_t, row_p1, row_p2;
  logic [AW-1:0]     col_t, col_p1, col_p2;
  logic              p1_on, p2_on;

  logic [RW-1:0]     row_t_next, row_p1_next, row_p2_next;
  logic [AW-1:0]     col_t_next, col_p1_next, col_p2_next;

  logic [31:0]       fw32;
  logic [WW-1:0]     w_clamp;
  logic [CFG_W-1:0]  h_clamp;
  logic [WW-1:0]     cur_w;
  logic [CFG_W-1:0]  cur_h;
  logic [MODE_W-1:0] cur_mode;
  logic [WW-1:0]     wm1;
  logic [RW-1:0]     hm1;
  logic              p1_act, p2_act;
  logic              ignore, fire, last;
  logic [PIXEL_BITS+PIX_PORT_W-1:0] pix_ext;

  // clamp the register values for a new frame
  always_comb begin
    fw32 = 32'(cfg.frame_width);
    if (fw32 < 32'd3) begin
      w_clamp = WW'(3);
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = fw32[WW-1:0];
    end
    h_clamp = (cfg.frame_height < 11'd3) ? 11'd3 : cfg.frame_height;
  end

  assign cur_w    = started ? act_w : w_clamp;
  assign cur_h    = started ? act_h : h_clamp;
  assign cur_mode = started ? act_mode : cfg.filter_mode;
  assign wm1      = cur_w - WW'(1);
  assign hm1      = {1'b0, cur_h} - RW'(1);

  // drain words before the input phase ends carry nothing
  assign ignore = pixels.drain && (row_t < {1'b0, cur_h});
  assign fire   = pixels.valid && push_ready;

  assign pixels.ready = push_ready;
  assign push_valid   = pixels.valid && !ignore;

  // window centers of the two stages start at fixed raster points
  assign p1_act = p1_on || (row_t == RW'(1) && col_t == AW'(1));
  assign p2_act = p2_on || (row_t == RW'(2) && col_t == AW'(2));
  assign last   = p2_act && (row_p2 == hm1) && (col_p2 == wm1[AW-1:0]);

  assign pix_ext  = {{PIXEL_BITS{1'b0}}, pixels.pixel_in};
  assign push_pix = pix_ext[PIXEL_BITS-1:0];
  assign push_col1 = col_t;
  assign push_col2 = col_p1;

  always_comb begin
    unique case (cur_mode)
      MODE_ERODE, MODE_OPEN: push_ctl.op1 = OP_AND;
      default:               push_ctl.op1 = OP_OR;
    endcase
    case (cur_mode) inside
      MODE_ERODE, MODE_DILATE: push_ctl.op2 = OP_PASS;
      MODE_OPEN:               push_ctl.op2 = OP_OR;
      default:                 push_ctl.op2 = OP_AND;
    endcase
    push_ctl.border1 = (row_p1 == '0) || (row_p1 >= hm1) ||
                       (col_p1 == '0) || (col_p1 == wm1[AW-1:0]);
    push_ctl.border2 = (row_p2 == '0) || (row_p2 >= hm1) ||
                       (col_p2 == '0) || (col_p2 == wm1[AW-1:0]);
    push_ctl.s2_en   = p1_act;
    push_ctl.out_en  = p2_act;
    push_ctl.last    = last;
  end

  // raster counters of the incoming word and the two centers
  always_comb begin
    if (col_t == wm1[AW-1:0]) begin
      col_t_next = '0;
      row_t_next = row_t + RW'(1);
    end else begin
      col_t_next = col_t + AW'(1);
      row_t_next = row_t;
    end
    col_p1_next = col_p1;
    row_p1_next = row_p1;
    if (p1_act) begin
      if (col_p1 == wm1[AW-1:0]) begin
        col_p1_next = '0;
        row_p1_next = row_p1 + RW'(1);
      end else begin
        col_p1_next = col_p1 + AW'(1);
      end
    end
    col_p2_next = col_p2;
    row_p2_next = row_p2;
    if (p2_act) begin
      if (col_p2 == wm1[AW-1:0]) begin
        col_p2_next = '0;
        row_p2_next = row_p2 + RW'(1);
      end else begin
        col_p2_next = col_p2 + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      act_w    <= WW'(RST_FRAME_WIDTH);
      act_h    <= RST_FRAME_HEIGHT;
      act_mode <= RST_FILTER_MODE;
      row_t    <= '0;
      col_t    <= '0;
      row_p1   <= '0;
      col_p1   <= '0;
      row_p2   <= '0;
      col_p2   <= '0;
      p1_on    <= 1'b0;
      p2_on    <= 1'b0;
    end else if (fire && !ignore) begin
      if (!started) begin
        act_w    <= w_clamp;
        act_h    <= h_clamp;
        act_mode <= cfg.filter_mode;
      end
      if (last) begin
        started <= 1'b0;
        row_t   <= '0;
        col_t   <= '0;
        row_p1  <= '0;
        col_p1  <= '0;
        row_p2  <= '0;
        col_p2  <= '0;
        p1_on   <= 1'b0;
        p2_on   <= 1'b0;
      end else begin
        started <= 1'b1;
        row_t   <= row_t_next;
        col_t   <= col_t_next;
        row_p1  <= row_p1_next;
        col_p1  <= col_p1_next;
        row_p2  <= row_p2_next;
        col_p2  <= col_p2_next;
        p1_on   <= p1_act;
        p2_on   <= p2_act;
      end
    end
  end

endmodule

[rtl/bm_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_window
// one 3x3 stage: two-line store in ram plus a column shift window
// ----------------------------------------------------------------------------
module bm_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         active,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic [PIXEL_BITS-1:0]        x,
  input  bm_pkg::op_t                  op,
  input  logic                         border,
  output logic [PIXEL_BITS-1:0]        result
);
  import bm_pkg::*;

  // rows of a column: [0] two lines up, [1] one line up, [2] current
  logic [2:0][PIXEL_BITS-1:0] c1, c2, cn;
  logic [2*PIXEL_BITS-1:0]    rdata;
  logic [PIXEL_BITS-1:0]      and9, or9;

  // ram word holds the same column of the two previous lines
  bm_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (en && active),
    .waddr (wr_addr),
    .wdata ({x, cn[1]}),
    .re    (en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign cn[2] = x;
  assign cn[1] = rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign cn[0] = rdata[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en && active) begin
      c2 <= c1;
      c1 <= cn;
    end
  end

  assign and9 = c2[0] & c2[1] & c2[2] & c1[0] & c1[1] & c1[2] & cn[0] & cn[1] & cn[2];
  assign or9  = c2[0] | c2[1] | c2[2] | c1[0] | c1[1] | c1[2] | cn[0] | cn[1] | cn[2];

  always_comb begin
    if (border) begin
      result = c1[1];
    end else begin
      case (op)
        OP_AND:  result = and9;
        OP_OR:   result = or9;
        default: result = c1[1];
      endcase
    end
  end

endmodule

[rtl/bm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm_back
// two cascaded window stages and the output register
// ----------------------------------------------------------------------------
module bm_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  bm_pkg::ctl_t                 pop_ctl,
  input  logic [PIXEL_BITS-1:0]        pop_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] pop_col1,
  input  logic [$clog2(MAX_WIDTH)-1:0] pop_col2,
  bm_out_if.source                     results
);
  import bm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic                  en;
  logic                  s0_valid, s1_valid, o_valid;
  ctl_t                  s0_ctl, s1_ctl;
  logic [PIXEL_BITS-1:0] s0_pix, s1_res, res1, res2, o_pix;
  logic [AW-1:0]         s0_col1, s0_col2, s1_col2;
  logic                  o_last;
  logic [PIXEL_BITS+PIX_PORT_W-1:0] o_ext;

  // whole pipe moves together, held only by a full output register
  assign en        = !o_valid || results.ready;
  assign pop_ready = en;

  bm_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_stage1 (
    .clk     (clk),
    .en      (en),
    .rd_addr (pop_col1),
    .active  (s0_valid),
    .wr_addr (s0_col1),
    .x       (s0_pix),
    .op      (s0_ctl.op1),
    .border  (s0_ctl.border1),
    .result  (res1)
  );

  bm_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_stage2 (
    .clk     (clk),
    .en      (en),
    .rd_addr (s0_col2),
    .active  (s1_valid && s1_ctl.s2_en),
    .wr_addr (s1_col2),
    .x       (s1_res),
    .op      (s1_ctl.op2),
    .border  (s1_ctl.border2),
    .result  (res2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctl  <= pop_ctl;
      s0_pix  <= pop_pix;
      s0_col1 <= pop_col1;
      s0_col2 <= pop_col2;
      s1_ctl  <= s0_ctl;
      s1_res  <= res1;
      s1_col2 <= s0_col2;
      o_pix   <= res2;
      o_last  <= s1_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else if (en) begin
      s0_valid <= pop_valid;
      s1_valid <= s0_valid;
      o_valid  <= s1_valid && s1_ctl.out_en;
    end
  end

  assign o_ext             = {{PIX_PORT_W{1'b0}}, o_pix};
  assign results.valid     = o_valid;
  assign results.pixel_out = o_ext[PIX_PORT_W-1:0];
  assign results.frame_end = o_last;

endmodule

[rtl/binary_morphology_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// 3x3 erosion, dilation, opening or closing on a raster pixel stream
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is taken, set by the single ram port pair per stage
// path: the completing word passes the queue, the s0 and s1 registers and the output register
// output pixel k is completed by word 2*W+2+k of the frame, drains included
// reset: registers go to 640 x 480 opening, positions clear, pipe empties;
// line stores are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
  parameter int MAX_WIDTH  = bm_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = bm_pkg::PIXEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bm_pkg::APB_AW-1:0] paddr,
  input  logic [bm_pkg::APB_DW-1:0] pwdata,
  output logic [bm_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  bm_in_if.sink                     pixels,
  bm_out_if.source                  results
);
  import bm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  // queue word: control, pixel, stage one column, stage two column
  localparam int QW = $bits(ctl_t) + PIXEL_BITS + 2 * AW;

  cfg_t                  cfg;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  logic                  push_valid, push_ready;
  ctl_t                  push_ctl;
  logic [PIXEL_BITS-1:0] push_pix;
  logic [AW-1:0]         push_col1, push_col2;

  logic                  pop_valid, pop_ready;
  ctl_t                  pop_ctl;
  logic [PIXEL_BITS-1:0] pop_pix;
  logic [AW-1:0]         pop_col1, pop_col2;
  logic [QW-1:0]         pop_data;

  // ---------------- configuration registers ----------------
  // word address selects the register, byte offset bits are ignored
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.filter_mode  <= RST_FILTER_MODE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[CFG_W-1:0];
        REG_FILTER_MODE:  cfg.filter_mode  <= pwdata[MODE_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(cfg.frame_height);
      REG_FILTER_MODE:  prdata = APB_DW'(cfg.filter_mode);
      default:          prdata = '0;
    endcase
  end

  // ---------------- front: positions, frame latch, classification ----------------
  // frame size and mode are latched on the first pixel of each frame
  bm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixels     (pixels),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_pix   (push_pix),
    .push_col1  (push_col1),
    .push_col2  (push_col2)
  );

  // ---------------- queue between front and back ----------------
  bm_fifo #(
    .WIDTH (QW),
    .DEPTH (FIFO_DEPTH_DEF)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_pix, push_col1, push_col2}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_ctl, pop_pix, pop_col1, pop_col2} = pop_data;

  // ---------------- back: two window stages and output word ----------------
  // stage one filters every word of the frame, stage two takes stage one
  // results once the first center is complete, output starts one line and one word later
  bm_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ctl   (pop_ctl),
    .pop_pix   (pop_pix),
    .pop_col1  (pop_col1),
    .pop_col2  (pop_col2),
    .results   (results)
  );

endmodule
